FILE: rtl/core/kov_pkg.sv
// Shared types, constants and rounding helpers of the Verlet orbit stepper.
package kov_pkg;

   // Field widths
   localparam int POS_W  = 53;
   localparam int VEL_W  = 46;
   localparam int ACC_W  = 64;
   localparam int MU_W   = 46;
   localparam int DT_W   = 16;
   localparam int DT2_W  = 2 * DT_W;
   localparam int CSR_W  = POS_W;
   localparam int IDX_W  = 3;

   // Fixed-point formats
   localparam int POS_FRAC_BITS = 24;
   localparam int VEL_FRAC_BITS = 40;
   localparam int ACC_FRAC_BITS = 60;
   localparam int MU_FRAC_BITS  = 8;
   localparam int POS_SH = ACC_FRAC_BITS + 1 - POS_FRAC_BITS;
   localparam int VEL_SH = ACC_FRAC_BITS + 1 - VEL_FRAC_BITS;
   localparam int G_SH   = ACC_FRAC_BITS - MU_FRAC_BITS + 2 * POS_FRAC_BITS;
   localparam int U_SH   = 62;

   // Arithmetic unit widths
   localparam int WIDE_W = 128;
   localparam int OPD_W  = 64;
   localparam int R2_W   = 106;
   localparam int ROOT_W = 54;
   localparam int SH_W   = 7;
   localparam int CNT_W  = 8;
   localparam int QUO_W  = 64;

   // Register indexes
   localparam logic [IDX_W-1:0] CSR_GRAV_PARAM = 3'd0;
   localparam logic [IDX_W-1:0] CSR_TIME_STEP  = 3'd1;
   localparam logic [IDX_W-1:0] CSR_INIT_POS_X = 3'd2;
   localparam logic [IDX_W-1:0] CSR_INIT_POS_Y = 3'd3;
   localparam logic [IDX_W-1:0] CSR_INIT_VEL_X = 3'd4;
   localparam logic [IDX_W-1:0] CSR_INIT_VEL_Y = 3'd5;

   // Register reset values
   localparam logic [MU_W-1:0]         GRAV_PARAM_RST = 46'd33984467712000;
   localparam logic [DT_W-1:0]         TIME_STEP_RST  = 16'd1000;
   localparam logic signed [POS_W-1:0] INIT_POS_X_RST = 53'sd2509871513600000;
   localparam logic signed [POS_W-1:0] INIT_POS_Y_RST = 53'sd0;
   localparam logic signed [VEL_W-1:0] INIT_VEL_X_RST = 46'sd0;
   localparam logic signed [VEL_W-1:0] INIT_VEL_Y_RST = 46'sd32204695577559;

   // Result status codes
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_SAT      = 2'd1;
   localparam logic [1:0] STATUS_NO_START = 2'd2;

   typedef enum logic [1:0] {
      OP_NONE,
      OP_MUL,
      OP_DIV,
      OP_SQRT
   } kov_op_type;

   typedef enum logic [4:0] {
      STEP_LOAD,
      STEP_PVX, STEP_PAX, STEP_PRX,
      STEP_PVY, STEP_PAY, STEP_PRY,
      STEP_SQX, STEP_SQY, STEP_CHK,
      STEP_ROOT, STEP_GRAV,
      STEP_UX, STEP_MX, STEP_UY, STEP_MY,
      STEP_VX1, STEP_VX2, STEP_VRX,
      STEP_VY1, STEP_VY2, STEP_VRY,
      STEP_FIN_R, STEP_FIN_A, STEP_NOSTART
   } kov_step_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_WAIT,
      ST_RESP
   } kov_state_type;

   typedef struct packed {
      logic         begin_item;
      logic         start;
      kov_step_type step;
   } kov_cmd_type;

   typedef struct packed {
      logic done;
      logic r2_zero;
      logic started;
   } kov_stat_type;

   typedef struct packed {
      logic [63:0] val;
      logic        sat;
   } kov_rnd_type;

   // Magnitude of a signed 64-bit value; the most negative value maps to 2^63
   function automatic logic [63:0] mag64(input logic signed [63:0] s);
      return s[63] ? 64'(-s) : 64'(s);
   endfunction

   // Round half up away sh fraction bits, then saturate to a signed w-bit value
   function automatic kov_rnd_type round_sat(input logic signed [WIDE_W-1:0] x,
                                             input int sh, input int w);
      logic signed [WIDE_W-1:0] t;
      logic signed [WIDE_W-1:0] lim_hi;
      logic signed [WIDE_W-1:0] lim_lo;
      kov_rnd_type r;
      t      = (x + (128'sd1 <<< (sh - 1))) >>> sh;
      lim_hi = (128'sd1 <<< (w - 1)) - 128'sd1;
      lim_lo = -(128'sd1 <<< (w - 1));
      r.val  = t[63:0];
      r.sat  = 1'b0;
      if (t > lim_hi) begin
         r.val = lim_hi[63:0];
         r.sat = 1'b1;
      end else if (t < lim_lo) begin
         r.val = lim_lo[63:0];
         r.sat = 1'b1;
      end
      return r;
   endfunction

endpackage

FILE: rtl/core/kov_arith.sv
// Shared iterative arithmetic unit: shift-add multiply, restoring divide, square root.
module kov_arith (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  kov_pkg::kov_op_type           op,
   input  logic [kov_pkg::OPD_W-1:0]     opa,
   input  logic [kov_pkg::OPD_W-1:0]     opb,
   input  logic [kov_pkg::R2_W-1:0]      opd,
   input  logic [kov_pkg::SH_W-1:0]      opsh,
   output logic                          done,
   output logic [kov_pkg::WIDE_W-1:0]    res,
   output logic                          sat
);

   localparam int W  = kov_pkg::WIDE_W;
   localparam int RW = kov_pkg::R2_W;
   localparam int QW = kov_pkg::QUO_W;
   localparam int NW = kov_pkg::ROOT_W;
   localparam int SRW = NW + 2;

   logic                     busy_ff;
   logic                     done_ff;
   kov_pkg::kov_op_type      op_ff;
   logic [kov_pkg::CNT_W-1:0] cnt_ff;

   logic [W-1:0]             acc_ff;
   logic [W-1:0]             ash_ff;
   logic [kov_pkg::OPD_W-1:0] bsh_ff;
   logic [RW-1:0]            rem_ff;
   logic [RW-1:0]            dvs_ff;
   logic [kov_pkg::OPD_W-1:0] num_ff;
   logic [QW-1:0]            quo_ff;
   logic                     sat_ff;
   logic [2*NW-1:0]          rad_ff;
   logic [SRW-1:0]           srem_ff;
   logic [NW-1:0]            root_ff;

   logic [RW:0]              div_rem_n;
   logic [RW:0]              div_rem_s;
   logic                     div_ge;
   logic [QW-1:0]            quo_n;
   logic [SRW+1:0]           sq_rem_n;
   logic [SRW+1:0]           sq_trial;
   logic                     sq_ge;
   logic                     fin;

   // One restoring divide step and one square-root digit step
   always_comb begin
      div_rem_n = {rem_ff, num_ff[kov_pkg::OPD_W-1]};
      div_ge    = div_rem_n >= {1'b0, dvs_ff};
      div_rem_s = div_rem_n - {1'b0, dvs_ff};
      quo_n     = {quo_ff[QW-2:0], div_ge};
      sq_rem_n  = {srem_ff, rad_ff[2*NW-1 -: 2]};
      sq_trial  = {2'b00, root_ff, 2'b01};
      sq_ge     = sq_rem_n >= sq_trial;
   end

   // Decide when the running operation has finished
   always_comb begin
      fin = 1'b0;
      if (busy_ff) begin
         unique case (op_ff)
            kov_pkg::OP_NONE: fin = 1'b1;
            kov_pkg::OP_MUL:  fin = (bsh_ff == '0);
            kov_pkg::OP_DIV:  fin = (cnt_ff == '0);
            kov_pkg::OP_SQRT: fin = (cnt_ff == '0);
            default:          fin = 1'b1;
         endcase
      end
   end

   // Sequence the operation
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         op_ff   <= kov_pkg::OP_NONE;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            op_ff   <= op;
            if (op == kov_pkg::OP_DIV) begin
               cnt_ff <= kov_pkg::CNT_W'(kov_pkg::QUO_W) + kov_pkg::CNT_W'(opsh);
            end else begin
               cnt_ff <= kov_pkg::CNT_W'(NW);
            end
         end else if (busy_ff) begin
            if (fin) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else if (op_ff == kov_pkg::OP_DIV && quo_n[QW-1]) begin
               cnt_ff <= '0;
            end else if (cnt_ff != '0) begin
               cnt_ff <= cnt_ff - 1'b1;
            end
         end
      end
   end

   // Advance the operands and partial results
   always_ff @(posedge clock) begin
      if (start) begin
         acc_ff  <= '0;
         ash_ff  <= W'(opa);
         bsh_ff  <= opb;
         rem_ff  <= '0;
         dvs_ff  <= opd;
         num_ff  <= opa;
         quo_ff  <= '0;
         sat_ff  <= 1'b0;
         rad_ff  <= (2*NW)'(opd);
         srem_ff <= '0;
         root_ff <= '0;
      end else if (busy_ff && !fin) begin
         unique case (op_ff)
            kov_pkg::OP_MUL: begin
               if (bsh_ff[0]) begin
                  acc_ff <= acc_ff + ash_ff;
               end
               ash_ff <= {ash_ff[W-2:0], 1'b0};
               bsh_ff <= {1'b0, bsh_ff[kov_pkg::OPD_W-1:1]};
            end
            kov_pkg::OP_DIV: begin
               rem_ff <= div_ge ? div_rem_s[RW-1:0] : div_rem_n[RW-1:0];
               num_ff <= {num_ff[kov_pkg::OPD_W-2:0], 1'b0};
               if (quo_n[QW-1]) begin
                  quo_ff <= {1'b0, {(QW-1){1'b1}}};
                  sat_ff <= 1'b1;
               end else begin
                  quo_ff <= quo_n;
               end
            end
            kov_pkg::OP_SQRT: begin
               srem_ff <= sq_ge ? SRW'(sq_rem_n - sq_trial) : SRW'(sq_rem_n);
               rad_ff  <= {rad_ff[2*NW-3:0], 2'b00};
               root_ff <= {root_ff[NW-2:0], sq_ge};
            end
            default: begin
            end
         endcase
      end
   end

   // Select the result of the finished operation
   always_comb begin
      unique case (op_ff)
         kov_pkg::OP_MUL:  res = acc_ff;
         kov_pkg::OP_DIV:  res = W'(quo_ff);
         kov_pkg::OP_SQRT: res = W'(root_ff);
         default:          res = '0;
      endcase
   end

   assign done = done_ff;
   assign sat  = sat_ff & (op_ff == kov_pkg::OP_DIV);

endmodule

FILE: rtl/core/kov_datapath.sv
// Datapath: registers, body state, operand selection and result write-back.
module kov_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr,
   input  logic [kov_pkg::IDX_W-1:0]          csr_index,
   input  logic [kov_pkg::CSR_W-1:0]          csr_data,
   input  kov_pkg::kov_cmd_type               cmd,
   output kov_pkg::kov_stat_type              stat,
   output logic [kov_pkg::POS_W-1:0]          pos_x,
   output logic [kov_pkg::POS_W-1:0]          pos_y,
   output logic [kov_pkg::VEL_W-1:0]          vel_x,
   output logic [kov_pkg::VEL_W-1:0]          vel_y,
   output logic [1:0]                         status
);

   localparam int PW = kov_pkg::POS_W;
   localparam int VW = kov_pkg::VEL_W;
   localparam int AW = kov_pkg::ACC_W;
   localparam int W  = kov_pkg::WIDE_W;
   localparam int MW = AW - 1;

   // Configuration registers
   logic [kov_pkg::MU_W-1:0] grav_param_ff;
   logic [kov_pkg::DT_W-1:0] time_step_ff;
   logic signed [PW-1:0]     init_pos_x_ff;
   logic signed [PW-1:0]     init_pos_y_ff;
   logic signed [VW-1:0]     init_vel_x_ff;
   logic signed [VW-1:0]     init_vel_y_ff;

   // Body state
   logic signed [PW-1:0]     body_pos_x_ff;
   logic signed [PW-1:0]     body_pos_y_ff;
   logic signed [VW-1:0]     body_vel_x_ff;
   logic signed [VW-1:0]     body_vel_y_ff;
   logic signed [AW-1:0]     body_acc_x_ff;
   logic signed [AW-1:0]     body_acc_y_ff;
   logic                     started_ff;
   logic [1:0]               status_ff;
   logic                     flag_ff;

   // Working registers
   logic signed [PW-1:0]     np_x_ff;
   logic signed [PW-1:0]     np_y_ff;
   logic signed [VW-1:0]     nv_x_ff;
   logic signed [VW-1:0]     nv_y_ff;
   logic signed [AW-1:0]     na_x_ff;
   logic signed [AW-1:0]     na_y_ff;
   logic signed [W-1:0]      sum_ff;
   logic [kov_pkg::R2_W-1:0] r2_ff;
   logic [kov_pkg::ROOT_W-1:0] root_ff;
   logic [MW-1:0]            g_ff;
   logic [MW-1:0]            u_ff;

   // Arithmetic unit hookup
   kov_pkg::kov_op_type      op;
   logic [kov_pkg::OPD_W-1:0] opa;
   logic [kov_pkg::OPD_W-1:0] opb;
   logic [kov_pkg::R2_W-1:0] opd;
   logic [kov_pkg::SH_W-1:0] opsh;
   logic                     neg;
   logic                     ar_done;
   logic [W-1:0]             ar_res;
   logic                     ar_sat;

   logic [kov_pkg::DT2_W-1:0] dt_sq;
   logic signed [W-1:0]      sprod;
   logic                     acc_sat;
   logic [MW-1:0]            acc_mag;
   logic signed [AW-1:0]     acc_pos;
   kov_pkg::kov_rnd_type     rnd_pos;
   kov_pkg::kov_rnd_type     rnd_vel;

   assign dt_sq = kov_pkg::DT2_W'(time_step_ff) * kov_pkg::DT2_W'(time_step_ff);

   // Select the operation and operands for each step
   always_comb begin
      op   = kov_pkg::OP_NONE;
      opa  = '0;
      opb  = '0;
      opd  = '0;
      opsh = '0;
      neg  = 1'b0;
      unique case (cmd.step)
         kov_pkg::STEP_PVX: begin
            op  = kov_pkg::OP_MUL;
            opa = kov_pkg::mag64(AW'(body_vel_x_ff));
            opb = kov_pkg::OPD_W'(time_step_ff);
            neg = body_vel_x_ff[VW-1];
         end
         kov_pkg::STEP_PAX: begin
            op  = kov_pkg::OP_MUL;
            opa = kov_pkg::mag64(body_acc_x_ff);
            opb = kov_pkg::OPD_W'(dt_sq);
            neg = body_acc_x_ff[AW-1];
         end
         kov_pkg::STEP_PVY: begin
            op  = kov_pkg::OP_MUL;
            opa = kov_pkg::mag64(AW'(body_vel_y_ff));
            opb = kov_pkg::OPD_W'(time_step_ff);
            neg = body_vel_y_ff[VW-1];
         end
         kov_pkg::STEP_PAY: begin
            op  = kov_pkg::OP_MUL;
            opa = kov_pkg::mag64(body_acc_y_ff);
            opb = kov_pkg::OPD_W'(dt_sq);
            neg = body_acc_y_ff[AW-1];
         end
         kov_pkg::STEP_SQX: begin
            op  = kov_pkg::OP_MUL;
            opa = kov_pkg::mag64(AW'(np_x_ff));
            opb = kov_pkg::mag64(AW'(np_x_ff));
         end
         kov_pkg::STEP_SQY: begin
            op  = kov_pkg::OP_MUL;
            opa = kov_pkg::mag64(AW'(np_y_ff));
            opb = kov_pkg::mag64(AW'(np_y_ff));
         end
         kov_pkg::STEP_ROOT: begin
            op  = kov_pkg::OP_SQRT;
            opd = r2_ff;
         end
         kov_pkg::STEP_GRAV: begin
            op   = kov_pkg::OP_DIV;
            opa  = kov_pkg::OPD_W'(grav_param_ff);
            opd  = r2_ff;
            opsh = kov_pkg::SH_W'(kov_pkg::G_SH);
         end
         kov_pkg::STEP_UX: begin
            op   = kov_pkg::OP_DIV;
            opa  = kov_pkg::mag64(AW'(np_x_ff));
            opd  = kov_pkg::R2_W'(root_ff);
            opsh = kov_pkg::SH_W'(kov_pkg::U_SH);
         end
         kov_pkg::STEP_UY: begin
            op   = kov_pkg::OP_DIV;
            opa  = kov_pkg::mag64(AW'(np_y_ff));
            opd  = kov_pkg::R2_W'(root_ff);
            opsh = kov_pkg::SH_W'(kov_pkg::U_SH);
         end
         kov_pkg::STEP_MX, kov_pkg::STEP_MY: begin
            op  = kov_pkg::OP_MUL;
            opa = {1'b0, g_ff};
            opb = {1'b0, u_ff};
         end
         kov_pkg::STEP_VX1: begin
            op  = kov_pkg::OP_MUL;
            opa = kov_pkg::mag64(body_acc_x_ff);
            opb = kov_pkg::OPD_W'(time_step_ff);
            neg = body_acc_x_ff[AW-1];
         end
         kov_pkg::STEP_VX2: begin
            op  = kov_pkg::OP_MUL;
            opa = kov_pkg::mag64(na_x_ff);
            opb = kov_pkg::OPD_W'(time_step_ff);
            neg = na_x_ff[AW-1];
         end
         kov_pkg::STEP_VY1: begin
            op  = kov_pkg::OP_MUL;
            opa = kov_pkg::mag64(body_acc_y_ff);
            opb = kov_pkg::OPD_W'(time_step_ff);
            neg = body_acc_y_ff[AW-1];
         end
         kov_pkg::STEP_VY2: begin
            op  = kov_pkg::OP_MUL;
            opa = kov_pkg::mag64(na_y_ff);
            opb = kov_pkg::OPD_W'(time_step_ff);
            neg = na_y_ff[AW-1];
         end
         default: begin
         end
      endcase
   end

   kov_arith u_arith (
      .clock (clock),
      .reset (reset),
      .start (cmd.start),
      .op    (op),
      .opa   (opa),
      .opb   (opb),
      .opd   (opd),
      .opsh  (opsh),
      .done  (ar_done),
      .res   (ar_res),
      .sat   (ar_sat)
   );

   // Signed product, acceleration magnitude and rounded sums
   always_comb begin
      sprod   = neg ? -signed'(ar_res) : signed'(ar_res);
      acc_sat = |ar_res[W-1:W-3];
      acc_mag = acc_sat ? {MW{1'b1}} : ar_res[W-4:kov_pkg::U_SH];
      acc_pos = signed'({1'b0, acc_mag});
      rnd_pos = kov_pkg::round_sat(sum_ff, kov_pkg::POS_SH, PW);
      rnd_vel = kov_pkg::round_sat(sum_ff, kov_pkg::VEL_SH, VW);
   end

   // Take configuration writes; unknown indexes drop
   always_ff @(posedge clock) begin
      if (reset) begin
         grav_param_ff <= kov_pkg::GRAV_PARAM_RST;
         time_step_ff  <= kov_pkg::TIME_STEP_RST;
         init_pos_x_ff <= kov_pkg::INIT_POS_X_RST;
         init_pos_y_ff <= kov_pkg::INIT_POS_Y_RST;
         init_vel_x_ff <= kov_pkg::INIT_VEL_X_RST;
         init_vel_y_ff <= kov_pkg::INIT_VEL_Y_RST;
      end else if (csr_wr) begin
         unique case (csr_index)
            kov_pkg::CSR_GRAV_PARAM: grav_param_ff <= csr_data[kov_pkg::MU_W-1:0];
            kov_pkg::CSR_TIME_STEP:  time_step_ff  <= csr_data[kov_pkg::DT_W-1:0];
            kov_pkg::CSR_INIT_POS_X: init_pos_x_ff <= signed'(csr_data[PW-1:0]);
            kov_pkg::CSR_INIT_POS_Y: init_pos_y_ff <= signed'(csr_data[PW-1:0]);
            kov_pkg::CSR_INIT_VEL_X: init_vel_x_ff <= signed'(csr_data[VW-1:0]);
            kov_pkg::CSR_INIT_VEL_Y: init_vel_y_ff <= signed'(csr_data[VW-1:0]);
            default: begin
            end
         endcase
      end
   end

   // Body state, flag and status
   always_ff @(posedge clock) begin
      if (reset) begin
         body_pos_x_ff <= '0;
         body_pos_y_ff <= '0;
         body_vel_x_ff <= '0;
         body_vel_y_ff <= '0;
         body_acc_x_ff <= '0;
         body_acc_y_ff <= '0;
         started_ff    <= 1'b0;
         status_ff     <= kov_pkg::STATUS_OK;
         flag_ff       <= 1'b0;
      end else if (cmd.begin_item) begin
         flag_ff <= 1'b0;
      end else if (ar_done) begin
         unique case (cmd.step)
            kov_pkg::STEP_LOAD: begin
               body_pos_x_ff <= init_pos_x_ff;
               body_pos_y_ff <= init_pos_y_ff;
               body_vel_x_ff <= init_vel_x_ff;
               body_vel_y_ff <= init_vel_y_ff;
            end
            kov_pkg::STEP_PRX: flag_ff <= flag_ff | rnd_pos.sat;
            kov_pkg::STEP_PRY: flag_ff <= flag_ff | rnd_pos.sat;
            kov_pkg::STEP_CHK: flag_ff <= flag_ff | (r2_ff == '0);
            kov_pkg::STEP_GRAV: flag_ff <= flag_ff | ar_sat;
            kov_pkg::STEP_UX: flag_ff <= flag_ff | ar_sat;
            kov_pkg::STEP_UY: flag_ff <= flag_ff | ar_sat;
            kov_pkg::STEP_MX: flag_ff <= flag_ff | acc_sat;
            kov_pkg::STEP_MY: flag_ff <= flag_ff | acc_sat;
            kov_pkg::STEP_VRX: flag_ff <= flag_ff | rnd_vel.sat;
            kov_pkg::STEP_VRY: flag_ff <= flag_ff | rnd_vel.sat;
            kov_pkg::STEP_FIN_R: begin
               body_acc_x_ff <= na_x_ff;
               body_acc_y_ff <= na_y_ff;
               started_ff    <= 1'b1;
               status_ff     <= flag_ff ? kov_pkg::STATUS_SAT : kov_pkg::STATUS_OK;
            end
            kov_pkg::STEP_FIN_A: begin
               body_pos_x_ff <= np_x_ff;
               body_pos_y_ff <= np_y_ff;
               body_vel_x_ff <= nv_x_ff;
               body_vel_y_ff <= nv_y_ff;
               body_acc_x_ff <= na_x_ff;
               body_acc_y_ff <= na_y_ff;
               status_ff     <= flag_ff ? kov_pkg::STATUS_SAT : kov_pkg::STATUS_OK;
            end
            kov_pkg::STEP_NOSTART: status_ff <= kov_pkg::STATUS_NO_START;
            default: begin
            end
         endcase
      end
   end

   // Working registers written back at the end of each step
   always_ff @(posedge clock) begin
      if (ar_done) begin
         unique case (cmd.step)
            kov_pkg::STEP_LOAD: begin
               np_x_ff <= init_pos_x_ff;
               np_y_ff <= init_pos_y_ff;
            end
            kov_pkg::STEP_PVX:
               sum_ff <= (W'(body_pos_x_ff) <<< kov_pkg::POS_SH) + (sprod <<< kov_pkg::VEL_SH);
            kov_pkg::STEP_PVY:
               sum_ff <= (W'(body_pos_y_ff) <<< kov_pkg::POS_SH) + (sprod <<< kov_pkg::VEL_SH);
            kov_pkg::STEP_PAX, kov_pkg::STEP_PAY, kov_pkg::STEP_VX2, kov_pkg::STEP_VY2:
               sum_ff <= sum_ff + sprod;
            kov_pkg::STEP_PRX: np_x_ff <= signed'(rnd_pos.val[PW-1:0]);
            kov_pkg::STEP_PRY: np_y_ff <= signed'(rnd_pos.val[PW-1:0]);
            kov_pkg::STEP_SQX: r2_ff <= ar_res[kov_pkg::R2_W-1:0];
            kov_pkg::STEP_SQY: r2_ff <= r2_ff + ar_res[kov_pkg::R2_W-1:0];
            kov_pkg::STEP_CHK: begin
               if (r2_ff == '0) begin
                  na_x_ff <= '0;
                  na_y_ff <= '0;
               end
            end
            kov_pkg::STEP_ROOT: root_ff <= ar_res[kov_pkg::ROOT_W-1:0];
            kov_pkg::STEP_GRAV: g_ff <= ar_res[MW-1:0];
            kov_pkg::STEP_UX, kov_pkg::STEP_UY: u_ff <= ar_res[MW-1:0];
            kov_pkg::STEP_MX: na_x_ff <= np_x_ff[PW-1] ? acc_pos : -acc_pos;
            kov_pkg::STEP_MY: na_y_ff <= np_y_ff[PW-1] ? acc_pos : -acc_pos;
            kov_pkg::STEP_VX1:
               sum_ff <= (W'(body_vel_x_ff) <<< kov_pkg::VEL_SH) + sprod;
            kov_pkg::STEP_VY1:
               sum_ff <= (W'(body_vel_y_ff) <<< kov_pkg::VEL_SH) + sprod;
            kov_pkg::STEP_VRX: nv_x_ff <= signed'(rnd_vel.val[VW-1:0]);
            kov_pkg::STEP_VRY: nv_y_ff <= signed'(rnd_vel.val[VW-1:0]);
            default: begin
            end
         endcase
      end
   end

   assign stat.done    = ar_done;
   assign stat.r2_zero = (r2_ff == '0);
   assign stat.started = started_ff;

   assign pos_x  = body_pos_x_ff;
   assign pos_y  = body_pos_y_ff;
   assign vel_x  = body_vel_x_ff;
   assign vel_y  = body_vel_y_ff;
   assign status = status_ff;

endmodule

FILE: rtl/core/kov_ctrl.sv
// Controller: step sequencer and stream handshakes.
module kov_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_restart,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  kov_pkg::kov_stat_type  stat,
   output kov_pkg::kov_cmd_type   cmd
);

   kov_pkg::kov_state_type state_ff, state_in;
   kov_pkg::kov_step_type  step_ff, step_in;
   kov_pkg::kov_step_type  step_next;
   logic                   mode_ff, mode_in;
   logic                   step_last;

   // Following step of the sequence
   always_comb begin
      step_last = 1'b0;
      step_next = kov_pkg::STEP_NOSTART;
      unique case (step_ff)
         kov_pkg::STEP_LOAD: step_next = kov_pkg::STEP_SQX;
         kov_pkg::STEP_PVX:  step_next = kov_pkg::STEP_PAX;
         kov_pkg::STEP_PAX:  step_next = kov_pkg::STEP_PRX;
         kov_pkg::STEP_PRX:  step_next = kov_pkg::STEP_PVY;
         kov_pkg::STEP_PVY:  step_next = kov_pkg::STEP_PAY;
         kov_pkg::STEP_PAY:  step_next = kov_pkg::STEP_PRY;
         kov_pkg::STEP_PRY:  step_next = kov_pkg::STEP_SQX;
         kov_pkg::STEP_SQX:  step_next = kov_pkg::STEP_SQY;
         kov_pkg::STEP_SQY:  step_next = kov_pkg::STEP_CHK;
         kov_pkg::STEP_CHK: begin
            if (!stat.r2_zero) begin
               step_next = kov_pkg::STEP_ROOT;
            end else if (mode_ff) begin
               step_next = kov_pkg::STEP_FIN_R;
            end else begin
               step_next = kov_pkg::STEP_VX1;
            end
         end
         kov_pkg::STEP_ROOT: step_next = kov_pkg::STEP_GRAV;
         kov_pkg::STEP_GRAV: step_next = kov_pkg::STEP_UX;
         kov_pkg::STEP_UX:   step_next = kov_pkg::STEP_MX;
         kov_pkg::STEP_MX:   step_next = kov_pkg::STEP_UY;
         kov_pkg::STEP_UY:   step_next = kov_pkg::STEP_MY;
         kov_pkg::STEP_MY:
            step_next = mode_ff ? kov_pkg::STEP_FIN_R : kov_pkg::STEP_VX1;
         kov_pkg::STEP_VX1:  step_next = kov_pkg::STEP_VX2;
         kov_pkg::STEP_VX2:  step_next = kov_pkg::STEP_VRX;
         kov_pkg::STEP_VRX:  step_next = kov_pkg::STEP_VY1;
         kov_pkg::STEP_VY1:  step_next = kov_pkg::STEP_VY2;
         kov_pkg::STEP_VY2:  step_next = kov_pkg::STEP_VRY;
         kov_pkg::STEP_VRY:  step_next = kov_pkg::STEP_FIN_A;
         kov_pkg::STEP_FIN_R, kov_pkg::STEP_FIN_A, kov_pkg::STEP_NOSTART:
            step_last = 1'b1;
         default: step_last = 1'b1;
      endcase
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      mode_in  = mode_ff;
      unique case (state_ff)
         kov_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               state_in = kov_pkg::ST_ISSUE;
               mode_in  = req_restart;
               priority if (req_restart) begin
                  step_in = kov_pkg::STEP_LOAD;
               end else if (stat.started) begin
                  step_in = kov_pkg::STEP_PVX;
               end else begin
                  step_in = kov_pkg::STEP_NOSTART;
               end
            end
         end
         kov_pkg::ST_ISSUE: state_in = kov_pkg::ST_WAIT;
         kov_pkg::ST_WAIT: begin
            if (stat.done) begin
               if (step_last) begin
                  state_in = kov_pkg::ST_RESP;
               end else begin
                  state_in = kov_pkg::ST_ISSUE;
                  step_in  = step_next;
               end
            end
         end
         kov_pkg::ST_RESP: begin
            if (rsp_tready) begin
               state_in = kov_pkg::ST_IDLE;
            end
         end
         default: state_in = kov_pkg::ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      req_tready     = (state_ff == kov_pkg::ST_IDLE);
      rsp_tvalid     = (state_ff == kov_pkg::ST_RESP);
      cmd.begin_item = (state_ff == kov_pkg::ST_IDLE) && req_tvalid;
      cmd.start      = (state_ff == kov_pkg::ST_ISSUE);
      cmd.step       = step_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= kov_pkg::ST_IDLE;
         step_ff  <= kov_pkg::STEP_NOSTART;
         mode_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         mode_ff  <= mode_in;
      end
   end

endmodule

FILE: rtl/core/kepler_orbit_verlet_step.sv
// Top level of the velocity Verlet two-body orbit stepper.
//
//   channel | direction | handshake              | payload
//   req     | in        | req_tvalid/req_tready  | req_tdata[0] restart
//   rsp     | out       | rsp_tvalid/rsp_tready  | rsp_tdata pos_x,pos_y,vel_x,vel_y,status
//   csr     | in        | csr_valid/csr_ready    | csr_index, csr_data
//
// One item at a time. The bit-serial divider and the shift-add multiplier, one bit
// of its second operand per cycle until the remaining bits are zero, set how long
// an advance or a restart takes.
// Reset is synchronous; body state clears and registers take their defaults.
// A stalled result holds the block: no new request is taken until it drains.
module kepler_orbit_verlet_step (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [7:0]                        req_tdata,   // [0] restart
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [52:0] pos_x, [105:53] pos_y, [151:106] vel_x, [197:152] vel_y, [199:198] status
   output logic [199:0]                      rsp_tdata,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [kov_pkg::IDX_W-1:0]         csr_index,
   input  logic [kov_pkg::CSR_W-1:0]         csr_data
);

   kov_pkg::kov_cmd_type  cmd;
   kov_pkg::kov_stat_type stat;
   logic [kov_pkg::POS_W-1:0] pos_x;
   logic [kov_pkg::POS_W-1:0] pos_y;
   logic [kov_pkg::VEL_W-1:0] vel_x;
   logic [kov_pkg::VEL_W-1:0] vel_y;
   logic [1:0]                status;

   assign csr_ready = 1'b1;

   kov_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_restart (req_tdata[0]),
      .req_tready  (req_tready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .stat        (stat),
      .cmd         (cmd)
   );

   kov_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_wr    (csr_valid & csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .stat      (stat),
      .pos_x     (pos_x),
      .pos_y     (pos_y),
      .vel_x     (vel_x),
      .vel_y     (vel_y),
      .status    (status)
   );

   // Pack the result, first field lowest
   assign rsp_tdata = {status, vel_y, vel_x, pos_y, pos_x};

endmodule

FILE: sim/tb_kepler_orbit_verlet_step.sv
// Self-checking testbench of the Verlet orbit stepper: predicted states against stream results.
`timescale 1ns / 100ps

module tb_kepler_orbit_verlet_step;
   import kov_pkg::*;

   localparam int LIMIT_CYCLES = 20_000_000;
   localparam int ITEM_TARGET  = 1900;

   // Bit-exact predictor of the orbit state and store of expected results
   class orbit_scoreboard;
      logic [MU_W-1:0]         mu;
      logic [DT_W-1:0]         dt;
      logic signed [POS_W-1:0] init_px, init_py;
      logic signed [VEL_W-1:0] init_vx, init_vy;
      logic signed [63:0]      px, py, vx, vy, ax, ay;
      bit                      started;
      logic [199:0]            expected_q[$];
      int                      errors, checked, sat_seen, nostart_seen;

      function new();
         mu = GRAV_PARAM_RST;
         dt = TIME_STEP_RST;
         init_px = INIT_POS_X_RST;
         init_py = INIT_POS_Y_RST;
         init_vx = INIT_VEL_X_RST;
         init_vy = INIT_VEL_Y_RST;
         px = 0; py = 0; vx = 0; vy = 0; ax = 0; ay = 0;
         started = 0;
         errors = 0; checked = 0; sat_seen = 0; nostart_seen = 0;
      endfunction

      function void write_reg(logic [IDX_W-1:0] idx, logic [CSR_W-1:0] data);
         case (idx)
            CSR_GRAV_PARAM: mu = data[MU_W-1:0];
            CSR_TIME_STEP:  dt = data[DT_W-1:0];
            CSR_INIT_POS_X: init_px = data[POS_W-1:0];
            CSR_INIT_POS_Y: init_py = data[POS_W-1:0];
            CSR_INIT_VEL_X: init_vx = data[VEL_W-1:0];
            CSR_INIT_VEL_Y: init_vy = data[VEL_W-1:0];
            default: ;
         endcase
      endfunction

      // Round half up away sh fraction bits, clamp to a signed w-bit range
      function logic signed [63:0] round_clamp(logic signed [127:0] x, int sh, int w,
                                               inout bit flag);
         logic signed [127:0] t, hi, lo;
         t  = (x + (128'sd1 <<< (sh - 1))) >>> sh;
         hi = (128'sd1 <<< (w - 1)) - 128'sd1;
         lo = -hi - 128'sd1;
         if (t > hi) begin
            flag = 1;
            return hi[63:0];
         end
         if (t < lo) begin
            flag = 1;
            return lo[63:0];
         end
         return t[63:0];
      endfunction

      function logic [63:0] magnitude(logic signed [63:0] s);
         return s < 0 ? 64'(-s) : 64'(s);
      endfunction

      // One axis of -g * p / r, g with 60 fraction bits
      function logic signed [63:0] axis_accel(logic [63:0] g, logic signed [63:0] p,
                                              logic [63:0] r, inout bit flag);
         logic [127:0] u, m;
         u = ({64'd0, magnitude(p)} << U_SH) / {64'd0, r};
         if (u >= 128'd1 << 63) begin
            flag = 1;
            u = (128'd1 << 63) - 1;
         end
         m = (128'(g) * u) >> 62;
         if (m >= 128'd1 << 63) begin
            flag = 1;
            m = (128'd1 << 63) - 1;
         end
         return p < 0 ? signed'(m[63:0]) : -signed'(m[63:0]);
      endfunction

      function void gravity(logic signed [63:0] qx, logic signed [63:0] qy,
                            output logic signed [63:0] gx, output logic signed [63:0] gy,
                            inout bit flag);
         logic [127:0] mx, my, r2;
         logic [63:0]  r, t, g;
         logic [191:0] q;
         mx = magnitude(qx);
         my = magnitude(qy);
         r2 = mx * mx + my * my;
         if (r2 == 0) begin
            gx = 0;
            gy = 0;
            flag = 1;
            return;
         end
         r = 0;
         for (int b = ROOT_W - 1; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (128'(t) * 128'(t) <= r2) r = t;
         end
         q = ({146'd0, mu} << G_SH) / {64'd0, r2};
         if (q >= 192'd1 << 63) begin
            flag = 1;
            g = 64'h7FFF_FFFF_FFFF_FFFF;
         end else begin
            g = q[63:0];
         end
         gx = axis_accel(g, qx, r, flag);
         gy = axis_accel(g, qy, r, flag);
      endfunction

      // Note an accepted item and queue the state it must produce
      function void note_item(bit restart);
         bit flag;
         logic [1:0] st;
         logic signed [127:0] d, sx, sy;
         logic signed [63:0] nx, ny, nax, nay;
         flag = 0;
         if (restart) begin
            px = init_px; py = init_py; vx = init_vx; vy = init_vy;
            gravity(px, py, ax, ay, flag);
            started = 1;
            st = flag ? STATUS_SAT : STATUS_OK;
         end else if (!started) begin
            st = STATUS_NO_START;
         end else begin
            d  = 128'(dt);
            sx = (128'(px) <<< POS_SH) + ((128'(vx) * d) <<< VEL_SH) + 128'(ax) * d * d;
            sy = (128'(py) <<< POS_SH) + ((128'(vy) * d) <<< VEL_SH) + 128'(ay) * d * d;
            nx = round_clamp(sx, POS_SH, POS_W, flag);
            ny = round_clamp(sy, POS_SH, POS_W, flag);
            gravity(nx, ny, nax, nay, flag);
            sx = (128'(vx) <<< VEL_SH) + 128'(ax) * d + 128'(nax) * d;
            sy = (128'(vy) <<< VEL_SH) + 128'(ay) * d + 128'(nay) * d;
            vx = round_clamp(sx, VEL_SH, VEL_W, flag);
            vy = round_clamp(sy, VEL_SH, VEL_W, flag);
            px = nx; py = ny; ax = nax; ay = nay;
            st = flag ? STATUS_SAT : STATUS_OK;
         end
         expected_q.push_back({st, vy[VEL_W-1:0], vx[VEL_W-1:0],
                               py[POS_W-1:0], px[POS_W-1:0]});
      endfunction

      function void check_result(logic [199:0] got);
         logic [199:0] exp_v;
         if (expected_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result transaction %h", got);
            return;
         end
         exp_v = expected_q.pop_front();
         checked++;
         if (got[199:198] == STATUS_SAT) sat_seen++;
         if (got[199:198] == STATUS_NO_START) nostart_seen++;
         if (got[52:0] !== exp_v[52:0] || got[105:53] !== exp_v[105:53] ||
             got[151:106] !== exp_v[151:106] || got[197:152] !== exp_v[197:152] ||
             got[199:198] !== exp_v[199:198]) begin
            errors++;
            if (errors <= 10) begin
               $display("mismatch at result %0d:", checked);
               $display("  pos_x exp %h got %h  pos_y exp %h got %h",
                        exp_v[52:0], got[52:0], exp_v[105:53], got[105:53]);
               $display("  vel_x exp %h got %h  vel_y exp %h got %h  status exp %0d got %0d",
                        exp_v[151:106], got[151:106], exp_v[197:152], got[197:152],
                        exp_v[199:198], got[199:198]);
            end
         end
      endfunction
   endclass

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [7:0]   req_tdata = '0;    // [0] restart
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   // [52:0] pos_x, [105:53] pos_y, [151:106] vel_x, [197:152] vel_y, [199:198] status
   logic [199:0] rsp_tdata;
   logic         csr_valid = 0;
   logic         csr_ready;
   logic [IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0] csr_data = '0;

   orbit_scoreboard orbit_sb = new();
   int  send_idle_pct, recv_idle_pct;
   int  cycle_count;
   int  items_sent, restarts_sent, reg_writes;

   kepler_orbit_verlet_step uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("kepler_orbit_verlet_step test failed");
         $finish;
      end
   end

   // Take results and throttle the result channel
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) orbit_sb.check_result(rsp_tdata);
      rsp_tready <= !reset && ($urandom_range(99) >= recv_idle_pct);
   end

   task automatic write_reg(logic [IDX_W-1:0] idx, logic [CSR_W-1:0] data);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      orbit_sb.write_reg(idx, data);
      reg_writes++;
      csr_valid <= 0;
      @(posedge clock);
   endtask

   task automatic send_item(bit restart);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata  <= {7'd0, restart};
      do @(posedge clock); while (!req_tready);
      orbit_sb.note_item(restart);
      items_sent++;
      if (restart) restarts_sent++;
   endtask

   // Hold off until every queued state has come back, then let the block settle
   task automatic drain();
      req_tvalid <= 0;
      @(posedge clock);
      while (orbit_sb.expected_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function automatic logic [CSR_W-1:0] rand_word();
      return CSR_W'({$urandom, $urandom});
   endfunction

   task automatic set_idle_by_progress();
      if (items_sent < ITEM_TARGET / 3) begin
         send_idle_pct = 16; recv_idle_pct = 86;
      end else if (items_sent < 2 * ITEM_TARGET / 3) begin
         send_idle_pct = 86; recv_idle_pct = 16;
      end else begin
         send_idle_pct = 0; recv_idle_pct = 0;
      end
   endtask

   task automatic load_orbit();
      write_reg(CSR_GRAV_PARAM, CSR_W'(GRAV_PARAM_RST));
      write_reg(CSR_INIT_POS_X, INIT_POS_X_RST);
      write_reg(CSR_INIT_POS_Y, INIT_POS_Y_RST);
      write_reg(CSR_INIT_VEL_X, CSR_W'(INIT_VEL_X_RST));
      write_reg(CSR_INIT_VEL_Y, CSR_W'(INIT_VEL_Y_RST));
   endtask

   initial begin
      int n, mode;
      cycle_count = 0;
      items_sent = 0; restarts_sent = 0; reg_writes = 0;
      send_idle_pct = 16; recv_idle_pct = 86;
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: advance before any restart, then the default orbit
      send_item(0);
      send_item(0);
      send_item(1);
      send_item(0);
      send_item(0);
      drain();
      // Zero step keeps the body still; unit step barely moves it
      write_reg(CSR_TIME_STEP, CSR_W'(16'd0));
      send_item(0);
      send_item(0);
      drain();
      write_reg(CSR_TIME_STEP, CSR_W'(16'd1));
      send_item(0);
      drain();
      // Body at the centre: zero radius
      write_reg(CSR_INIT_POS_X, '0);
      send_item(1);
      send_item(0);
      drain();
      // Field extremes and the longest step, to drive the arithmetic into saturation
      write_reg(CSR_GRAV_PARAM, CSR_W'({MU_W{1'b1}}));
      write_reg(CSR_TIME_STEP, CSR_W'(16'hFFFF));
      write_reg(CSR_INIT_POS_X, {1'b0, {(POS_W-1){1'b1}}});
      write_reg(CSR_INIT_POS_Y, {1'b1, {(POS_W-1){1'b0}}});
      write_reg(CSR_INIT_VEL_X, CSR_W'({1'b1, {(VEL_W-1){1'b0}}}));
      write_reg(CSR_INIT_VEL_Y, CSR_W'({1'b0, {(VEL_W-1){1'b1}}}));
      send_item(1);
      send_item(0);
      send_item(0);
      drain();
      // Tiny radius under the largest mass: gravity term clamps on restart
      write_reg(CSR_INIT_POS_X, 53'd1);
      write_reg(CSR_INIT_POS_Y, '0);
      send_item(1);
      send_item(0);
      drain();
      // Massless centre: straight-line motion
      write_reg(CSR_GRAV_PARAM, '0);
      write_reg(CSR_TIME_STEP, CSR_W'(TIME_STEP_RST));
      send_item(1);
      send_item(0);
      drain();
      // Out-of-range indexes must leave every register alone
      write_reg(3'd6, rand_word());
      write_reg(3'd7, rand_word());
      load_orbit();
      send_item(1);
      send_item(0);
      drain();

      // Random phases: mostly long orbits from a restart, some wild settings
      while (items_sent < ITEM_TARGET) begin
         set_idle_by_progress();
         mode = $urandom_range(9);
         if (mode < 6) begin
            load_orbit();
            write_reg(CSR_TIME_STEP, CSR_W'($urandom_range(1, 20000)));
            write_reg(CSR_INIT_VEL_Y,
                      CSR_W'(INIT_VEL_Y_RST + $signed(CSR_W'($urandom_range(0, 2**30)))
                             - (1 << 29)));
         end else if (mode < 9) begin
            for (int i = 0; i < 6; i++) write_reg(i[IDX_W-1:0], rand_word());
            if ($urandom_range(1)) write_reg(CSR_TIME_STEP, CSR_W'($urandom_range(0, 64)));
         end else begin
            write_reg(CSR_GRAV_PARAM, $urandom_range(1) ? '0 : CSR_W'({MU_W{1'b1}}));
            write_reg(CSR_TIME_STEP, CSR_W'($urandom_range(1) ? 16'd0 : 16'hFFFF));
            write_reg(CSR_INIT_POS_X, $urandom_range(1) ? '0 : rand_word());
            write_reg(3'($urandom_range(6, 7)), rand_word());
         end
         n = $urandom_range(30, 80);
         send_item(1);
         for (int i = 1; i < n; i++) send_item($urandom_range(24) == 0);
         drain();
      end

      $display("covered %0d items (%0d restarts) and %0d register writes over %0d cycles",
               items_sent, restarts_sent, reg_writes, cycle_count);
      $display("checked %0d states: %0d saturated, %0d before any restart",
               orbit_sb.checked, orbit_sb.sat_seen, orbit_sb.nostart_seen);
      if (orbit_sb.errors == 0 && orbit_sb.expected_q.size() == 0) begin
         $display("kepler_orbit_verlet_step test passed");
      end else begin
         $display("%0d mismatches, %0d states missing",
                  orbit_sb.errors, orbit_sb.expected_q.size());
         $display("kepler_orbit_verlet_step test failed");
      end
      $finish;
   end

endmodule
